>>> src/looped_phrase_note_scheduler_assert.svh
// Assertion helpers for the phrase note scheduler.
`ifndef LOOPED_PHRASE_NOTE_SCHEDULER_ASSERT_SVH
`define LOOPED_PHRASE_NOTE_SCHEDULER_ASSERT_SVH

// Same-cycle implication, quiet while reset is held.
`define LPNS_CHECK_NOW(lbl, ante, cons, txt) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(txt);

// Next-cycle implication, quiet while reset is held.
`define LPNS_CHECK_NEXT(lbl, ante, cons, txt) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(txt);

`endif

>>> src/lpns_pkg.sv
package lpns_pkg;

  localparam int MAX_EVENTS  = 16;
  localparam int EV_IW       = $clog2(MAX_EVENTS);
  localparam int EV_CW       = $clog2(MAX_EVENTS + 1);
  localparam int MAX_PENDING = 64;
  localparam int PEND_AW     = $clog2(MAX_PENDING);
  localparam int PEND_CW     = $clog2(MAX_PENDING + 1);

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_SCHED = 2'd2;

  localparam logic [1:0] ST_MSG  = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic KIND_ON  = 1'b0;
  localparam logic KIND_OFF = 1'b1;

  localparam logic CFG_LEN  = 1'b0;
  localparam logic CFG_CHAN = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FDIV,
    S_EV,
    S_ADIV,
    S_BDIV,
    S_CLAMP,
    S_SPAN,
    S_REP,
    S_INS,
    S_INS_CMP,
    S_INS_END,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_HOLD,
    S_STAT
  } state_t;

  typedef struct packed {
    logic [32:0]      tick;
    logic             kind;
    logic [31:0]      rep;
    logic [EV_IW-1:0] idx;
    logic [6:0]       note;
    logic [6:0]       vel;
  } msg_t;

  // Order: tick, then note-off first, then repeat, then table slot.
  function automatic logic msg_before(input msg_t a, input msg_t b);
    logic r;
    if (a.tick != b.tick) begin
      r = (a.tick < b.tick);
    end else if (a.kind != b.kind) begin
      r = a.kind;
    end else if (a.rep != b.rep) begin
      r = (a.rep < b.rep);
    end else begin
      r = (a.idx < b.idx);
    end
    return r;
  endfunction

endpackage

>>> src/looped_phrase_note_scheduler.sv
// Clear and add are done on acceptance in the idle state; add to a full table returns one status result.
// Schedule: the shared restoring divider first finds the first repeat index, then
// per event and per pass finds its repeat range; each message is then inserted in
// order by shifting, and each result is read back from memory and sent.
// One request is worked at a time; in_tready is high only while idle.
// rst_n (synchronous) clears the event count and channel, sets the phrase length to 3840 and resets control.
module looped_phrase_note_scheduler (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // event_tick[31:0], event_note[38:32], event_velocity[45:39],
  // event_duration[77:46], window_start[109:78], window_end[141:110], zero pad
  input  logic [143:0] in_tdata,
  // op[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // channel[3:0], note[10:4], velocity[17:11], time_tick[50:18], zero pad
  output logic [55:0]  out_tdata,
  // status[1:0], kind[2]
  output logic [2:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  lpns_pkg::state_t state_r, state_nxt;

  logic [31:0] len_r;
  logic [3:0]  chan_r;
  logic [lpns_pkg::EV_CW-1:0] evcnt_r, evcnt_nxt;

  logic [31:0] ev_off [lpns_pkg::MAX_EVENTS];
  logic [31:0] ev_dur [lpns_pkg::MAX_EVENTS];
  logic [6:0]  ev_note [lpns_pkg::MAX_EVENTS];
  logic [6:0]  ev_vel [lpns_pkg::MAX_EVENTS];
  logic        ev_we;

  logic [31:0] start_r, start_nxt, endm1_r, endm1_nxt;
  logic [31:0] first_r, first_nxt, rf_r, rf_nxt;
  logic [lpns_pkg::EV_CW-1:0] e_r, e_nxt;
  logic        pass_r, pass_nxt;
  logic [lpns_pkg::PEND_CW-1:0] total_r, total_nxt;
  logic [32:0] a_r, a_nxt, atick_r, atick_nxt;
  logic [31:0] b_r, b_nxt, k_r, k_nxt, tick_r, tick_nxt;
  logic        half_r, half_nxt;
  lpns_pkg::msg_t cur_r, cur_nxt;
  logic [lpns_pkg::PEND_CW-1:0] j_r, j_nxt, n_r, n_nxt;
  logic [lpns_pkg::PEND_AW-1:0] oi_r, oi_nxt;

  logic [31:0] dnum_r, dnum_nxt, drem_r, drem_nxt;
  logic [5:0]  dcnt_r, dcnt_nxt;
  logic        div_ld;
  logic [31:0] div_val;
  logic [32:0] rem_sh, rem_sub;
  logic        rem_ge, div_done, div_run;

  logic        ovalid_r, ovalid_nxt, olast_r, olast_nxt;
  logic [2:0]  ouser_r, ouser_nxt;
  logic [55:0] odata_r, odata_nxt;

  lpns_pkg::msg_t pend_mem [lpns_pkg::MAX_PENDING];
  lpns_pkg::msg_t rd_r, mem_wdata;
  logic        mem_we;
  logic [lpns_pkg::PEND_AW-1:0] mem_waddr, mem_raddr;

  logic        in_acc;
  logic [1:0]  in_op;
  logic [31:0] in_tick, in_dur, in_start, in_end;
  logic [6:0]  in_note, in_vel;
  logic [lpns_pkg::EV_IW-1:0] ei;
  logic [31:0] off_e;
  logic        ev_at_end, off_past, off_ge;
  logic        sched_ok, table_full;
  logic [32:0] span;
  logic [lpns_pkg::PEND_CW:0] total_sum;
  logic        span_empty, span_ovf;
  logic        ins_before, ins_at_top, rep_last;

  function automatic logic [lpns_pkg::PEND_AW-1:0] PEND_AW_M1(
    input logic [lpns_pkg::PEND_CW-1:0] v);
    logic [lpns_pkg::PEND_CW-1:0] d;
    d = v - lpns_pkg::PEND_CW'(1);
    return d[lpns_pkg::PEND_AW-1:0];
  endfunction

  assign in_op    = in_tuser;
  assign in_tick  = in_tdata[31:0];
  assign in_note  = in_tdata[38:32];
  assign in_vel   = in_tdata[45:39];
  assign in_dur   = in_tdata[77:46];
  assign in_start = in_tdata[109:78];
  assign in_end   = in_tdata[141:110];

  assign in_acc     = in_tvalid && in_tready;
  assign ei         = e_r[lpns_pkg::EV_IW-1:0];
  assign off_e      = ev_off[ei];
  assign ev_at_end  = (e_r == evcnt_r);
  assign off_past   = (off_e > endm1_r);
  assign off_ge     = (off_e >= start_r);
  assign sched_ok   = (in_end > in_start) && (len_r != 32'd0);
  assign table_full = (evcnt_r == lpns_pkg::EV_CW'(lpns_pkg::MAX_EVENTS));
  assign span       = {1'b0, b_r} - a_r + 33'd1;
  assign total_sum  = {1'b0, total_r} + {span[lpns_pkg::PEND_CW-1:0], 1'b0};
  assign span_empty = (a_r > {1'b0, b_r});
  assign span_ovf   = (span > 33'(lpns_pkg::MAX_PENDING / 2)) ||
                      (total_sum > (lpns_pkg::PEND_CW + 1)'(lpns_pkg::MAX_PENDING));
  assign ins_before = lpns_pkg::msg_before(cur_r, rd_r);
  assign ins_at_top = (j_r == '0);
  assign rep_last   = (k_r == b_r);

  // shared restoring divider, divisor is the phrase length
  assign rem_sh   = {drem_r, dnum_r[31]};
  assign rem_sub  = rem_sh - {1'b0, len_r};
  assign rem_ge   = (rem_sh >= {1'b0, len_r});
  assign div_done = (dcnt_r == 6'd0);
  assign div_run  = (state_r == lpns_pkg::S_FDIV) || (state_r == lpns_pkg::S_ADIV) ||
                    (state_r == lpns_pkg::S_BDIV);

  always_comb begin
    dnum_nxt = dnum_r;
    drem_nxt = drem_r;
    dcnt_nxt = dcnt_r;
    if (div_ld) begin
      dnum_nxt = div_val;
      drem_nxt = '0;
      dcnt_nxt = 6'd32;
    end else if (div_run && !div_done) begin
      dnum_nxt = {dnum_r[30:0], rem_ge};
      drem_nxt = rem_ge ? rem_sub[31:0] : rem_sh[31:0];
      dcnt_nxt = dcnt_r - 6'd1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpns_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_op == lpns_pkg::OP_ADD && table_full) begin
            state_nxt = lpns_pkg::S_STAT;
          end else if (in_op == lpns_pkg::OP_SCHED && sched_ok) begin
            state_nxt = lpns_pkg::S_FDIV;
          end
        end
      end
      lpns_pkg::S_FDIV: if (div_done) state_nxt = lpns_pkg::S_EV;
      lpns_pkg::S_EV: begin
        if (ev_at_end) begin
          if (pass_r) begin
            state_nxt = lpns_pkg::S_OUT_RD;
          end else if (total_r == '0) begin
            state_nxt = lpns_pkg::S_IDLE;
          end
        end else if (!off_past) begin
          state_nxt = off_ge ? lpns_pkg::S_BDIV : lpns_pkg::S_ADIV;
        end
      end
      lpns_pkg::S_ADIV: if (div_done) state_nxt = lpns_pkg::S_BDIV;
      lpns_pkg::S_BDIV: if (div_done) state_nxt = lpns_pkg::S_CLAMP;
      lpns_pkg::S_CLAMP: state_nxt = lpns_pkg::S_SPAN;
      lpns_pkg::S_SPAN: begin
        if (span_empty) begin
          state_nxt = lpns_pkg::S_EV;
        end else if (pass_r) begin
          state_nxt = lpns_pkg::S_REP;
        end else begin
          state_nxt = span_ovf ? lpns_pkg::S_STAT : lpns_pkg::S_EV;
        end
      end
      lpns_pkg::S_REP: state_nxt = lpns_pkg::S_INS;
      lpns_pkg::S_INS: state_nxt = ins_at_top ? lpns_pkg::S_INS_END : lpns_pkg::S_INS_CMP;
      lpns_pkg::S_INS_CMP: state_nxt = ins_before ? lpns_pkg::S_INS : lpns_pkg::S_INS_END;
      lpns_pkg::S_INS_END: begin
        if (half_r && rep_last) begin
          state_nxt = lpns_pkg::S_EV;
        end else begin
          state_nxt = lpns_pkg::S_REP;
        end
      end
      lpns_pkg::S_OUT_RD: state_nxt = lpns_pkg::S_OUT_LD;
      lpns_pkg::S_OUT_LD: state_nxt = lpns_pkg::S_OUT_HOLD;
      lpns_pkg::S_OUT_HOLD: begin
        if (out_tready) begin
          state_nxt = olast_r ? lpns_pkg::S_IDLE : lpns_pkg::S_OUT_RD;
        end
      end
      lpns_pkg::S_STAT: if (out_tready) state_nxt = lpns_pkg::S_IDLE;
      default: state_nxt = lpns_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake, divider load, memory port, table write
  always_comb begin
    in_tready = (state_r == lpns_pkg::S_IDLE);
    div_ld    = 1'b0;
    div_val   = endm1_r - off_e;
    mem_we    = 1'b0;
    mem_waddr = j_r[lpns_pkg::PEND_AW-1:0];
    mem_wdata = cur_r;
    mem_raddr = oi_r;
    ev_we     = 1'b0;
    case (state_r)
      lpns_pkg::S_IDLE: begin
        if (in_acc && in_op == lpns_pkg::OP_ADD && !table_full) begin
          ev_we = 1'b1;
        end
        if (in_acc && in_op == lpns_pkg::OP_SCHED && sched_ok) begin
          div_ld  = 1'b1;
          div_val = in_start;
        end
      end
      lpns_pkg::S_EV: begin
        if (!ev_at_end && !off_past) begin
          div_ld = 1'b1;
          if (!off_ge) begin
            div_val = start_r - off_e - 32'd1;
          end
        end
      end
      lpns_pkg::S_ADIV: div_ld = div_done;
      lpns_pkg::S_INS: begin
        mem_raddr = PEND_AW_M1(j_r);
        if (ins_at_top) begin
          mem_we = 1'b1;
        end
      end
      lpns_pkg::S_INS_CMP: begin
        mem_we = 1'b1;
        if (ins_before) begin
          mem_wdata = rd_r;
        end
      end
      default: begin
      end
    endcase
  end

  // datapath registers
  always_comb begin
    evcnt_nxt  = evcnt_r;
    start_nxt  = start_r;
    endm1_nxt  = endm1_r;
    first_nxt  = first_r;
    rf_nxt     = rf_r;
    e_nxt      = e_r;
    pass_nxt   = pass_r;
    total_nxt  = total_r;
    a_nxt      = a_r;
    atick_nxt  = atick_r;
    b_nxt      = b_r;
    k_nxt      = k_r;
    tick_nxt   = tick_r;
    half_nxt   = half_r;
    cur_nxt    = cur_r;
    j_nxt      = j_r;
    n_nxt      = n_r;
    oi_nxt     = oi_r;
    ovalid_nxt = ovalid_r;
    olast_nxt  = olast_r;
    ouser_nxt  = ouser_r;
    odata_nxt  = odata_r;
    case (state_r)
      lpns_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            lpns_pkg::OP_CLEAR: evcnt_nxt = '0;
            lpns_pkg::OP_ADD: begin
              if (table_full) begin
                ovalid_nxt = 1'b1;
                olast_nxt  = 1'b1;
                ouser_nxt  = {lpns_pkg::KIND_ON, lpns_pkg::ST_FULL};
                odata_nxt  = '0;
              end else begin
                evcnt_nxt = evcnt_r + lpns_pkg::EV_CW'(1);
              end
            end
            lpns_pkg::OP_SCHED: begin
              start_nxt = in_start;
              endm1_nxt = in_end - 32'd1;
            end
            default: begin
            end
          endcase
        end
      end
      lpns_pkg::S_FDIV: begin
        if (div_done) begin
          first_nxt = dnum_r;
          rf_nxt    = drem_r;
          e_nxt     = '0;
          pass_nxt  = 1'b0;
          total_nxt = '0;
          n_nxt     = '0;
        end
      end
      lpns_pkg::S_EV: begin
        if (ev_at_end) begin
          if (!pass_r) begin
            pass_nxt = 1'b1;
            e_nxt    = '0;
          end
          oi_nxt = '0;
        end else if (off_past) begin
          e_nxt = e_r + lpns_pkg::EV_CW'(1);
        end else if (off_ge) begin
          a_nxt     = '0;
          atick_nxt = {1'b0, off_e};
        end
      end
      lpns_pkg::S_ADIV: begin
        if (div_done) begin
          // first repeat at or past the window start, and its tick
          a_nxt     = {1'b0, dnum_r} + 33'd1;
          atick_nxt = {1'b0, start_r} + {1'b0, len_r - 32'd1 - drem_r};
        end
      end
      lpns_pkg::S_BDIV: if (div_done) b_nxt = dnum_r;
      lpns_pkg::S_CLAMP: begin
        if (a_r < {1'b0, first_r}) begin
          a_nxt     = {1'b0, first_r};
          atick_nxt = {1'b0, start_r - rf_r} + {1'b0, off_e};
        end
      end
      lpns_pkg::S_SPAN: begin
        if (span_empty) begin
          e_nxt = e_r + lpns_pkg::EV_CW'(1);
        end else if (pass_r) begin
          k_nxt    = a_r[31:0];
          tick_nxt = atick_r[31:0];
          half_nxt = 1'b0;
        end else if (span_ovf) begin
          ovalid_nxt = 1'b1;
          olast_nxt  = 1'b1;
          ouser_nxt  = {lpns_pkg::KIND_ON, lpns_pkg::ST_OVF};
          odata_nxt  = '0;
        end else begin
          total_nxt = total_sum[lpns_pkg::PEND_CW-1:0];
          e_nxt     = e_r + lpns_pkg::EV_CW'(1);
        end
      end
      lpns_pkg::S_REP: begin
        cur_nxt.kind = half_r;
        cur_nxt.rep  = k_r;
        cur_nxt.idx  = ei;
        cur_nxt.note = ev_note[ei];
        if (half_r) begin
          cur_nxt.tick = {1'b0, tick_r} + {1'b0, ev_dur[ei]};
          cur_nxt.vel  = '0;
        end else begin
          cur_nxt.tick = {1'b0, tick_r};
          cur_nxt.vel  = ev_vel[ei];
        end
        j_nxt = n_r;
      end
      lpns_pkg::S_INS_CMP: begin
        if (ins_before) begin
          j_nxt = j_r - lpns_pkg::PEND_CW'(1);
        end
      end
      lpns_pkg::S_INS_END: begin
        n_nxt = n_r + lpns_pkg::PEND_CW'(1);
        if (!half_r) begin
          half_nxt = 1'b1;
        end else begin
          half_nxt = 1'b0;
          if (rep_last) begin
            e_nxt = e_r + lpns_pkg::EV_CW'(1);
          end else begin
            k_nxt    = k_r + 32'd1;
            tick_nxt = tick_r + len_r;
          end
        end
      end
      lpns_pkg::S_OUT_LD: begin
        ovalid_nxt = 1'b1;
        olast_nxt  = ({1'b0, oi_r} + lpns_pkg::PEND_CW'(1) == n_r);
        ouser_nxt  = {rd_r.kind, lpns_pkg::ST_MSG};
        odata_nxt  = {5'd0, rd_r.tick, rd_r.vel, rd_r.note, chan_r};
      end
      lpns_pkg::S_OUT_HOLD: begin
        if (out_tready) begin
          ovalid_nxt = 1'b0;
          oi_nxt     = oi_r + lpns_pkg::PEND_AW'(1);
        end
      end
      lpns_pkg::S_STAT: if (out_tready) ovalid_nxt = 1'b0;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lpns_pkg::S_IDLE;
      len_r    <= 32'd3840;
      chan_r   <= '0;
      evcnt_r  <= '0;
      ovalid_r <= 1'b0;
      dcnt_r   <= '0;
      n_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      evcnt_r  <= evcnt_nxt;
      ovalid_r <= ovalid_nxt;
      dcnt_r   <= dcnt_nxt;
      n_r      <= n_nxt;
      if (cfg_we) begin
        if (cfg_addr == lpns_pkg::CFG_LEN) begin
          len_r <= cfg_wdata;
        end else begin
          chan_r <= cfg_wdata[3:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    endm1_r <= endm1_nxt;
    first_r <= first_nxt;
    rf_r    <= rf_nxt;
    e_r     <= e_nxt;
    pass_r  <= pass_nxt;
    total_r <= total_nxt;
    a_r     <= a_nxt;
    atick_r <= atick_nxt;
    b_r     <= b_nxt;
    k_r     <= k_nxt;
    tick_r  <= tick_nxt;
    half_r  <= half_nxt;
    cur_r   <= cur_nxt;
    j_r     <= j_nxt;
    oi_r    <= oi_nxt;
    dnum_r  <= dnum_nxt;
    drem_r  <= drem_nxt;
    olast_r <= olast_nxt;
    ouser_r <= ouser_nxt;
    odata_r <= odata_nxt;
  end

  always_ff @(posedge clk) begin
    if (ev_we) begin
      ev_off[evcnt_r[lpns_pkg::EV_IW-1:0]]  <= in_tick;
      ev_dur[evcnt_r[lpns_pkg::EV_IW-1:0]]  <= in_dur;
      ev_note[evcnt_r[lpns_pkg::EV_IW-1:0]] <= in_note;
      ev_vel[evcnt_r[lpns_pkg::EV_IW-1:0]]  <= in_vel;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pend_mem[mem_waddr] <= mem_wdata;
    end
    rd_r <= pend_mem[mem_raddr];
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;

`include "looped_phrase_note_scheduler_assert.svh"

  `LPNS_CHECK_NOW(a_ready_no_result, in_tready, !out_tvalid,
    "request taken while a result is pending")
  `LPNS_CHECK_NOW(a_evcnt_range, 1'b1,
    evcnt_r <= lpns_pkg::EV_CW'(lpns_pkg::MAX_EVENTS), "event count past table size")
  `LPNS_CHECK_NOW(a_status_last, out_tvalid && (out_tuser[1:0] != lpns_pkg::ST_MSG),
    out_tlast, "status result without last")
  `LPNS_CHECK_NEXT(a_full_status, in_tvalid && in_tready && in_tuser == lpns_pkg::OP_ADD &&
    table_full, out_tvalid && out_tuser[1:0] == lpns_pkg::ST_FULL, "table full not reported")

endmodule

>>> tb/looped_phrase_note_scheduler_tb.sv
module looped_phrase_note_scheduler_tb;

  // op code the block ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] ev_tick;
    logic [6:0]  ev_note;
    logic [6:0]  ev_vel;
    logic [31:0] ev_dur;
    logic [31:0] win_start;
    logic [31:0] win_end;
  } request_t;

  typedef struct {
    logic [1:0]  status;
    logic        kind;
    logic [3:0]  channel;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [32:0] tick;
    logic        last;
  } note_msg_t;

  typedef struct {
    logic [32:0] tick;
    logic        kind;
    longint unsigned rep;
    int          slot;
    logic [6:0]  note;
    logic [6:0]  vel;
  } sort_entry_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [55:0]  out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_we = 1'b0;
  logic         cfg_addr = 1'b0;
  logic [31:0]  cfg_wdata = '0;

  // predictor state
  logic [31:0] phrase_len;
  logic [3:0]  midi_chan;
  logic [31:0] tbl_off [lpns_pkg::MAX_EVENTS];
  logic [31:0] tbl_dur [lpns_pkg::MAX_EVENTS];
  logic [6:0]  tbl_note [lpns_pkg::MAX_EVENTS];
  logic [6:0]  tbl_vel [lpns_pkg::MAX_EVENTS];
  int          tbl_count;

  note_msg_t   expected_msgs[$];
  int          errors = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          hold_cycles = 0;
  bit          hold_req = 1'b0;
  bit          hold_ack = 1'b0;

  looped_phrase_note_scheduler DUT (.*);

  always #2 clk = ~clk;

  task automatic report_mismatch(string what, longint unsigned exp_v, longint unsigned got_v);
    $display("mismatch %s: expected %0h got %0h at %0t", what, exp_v, got_v, $time);
    errors++;
  endtask

  // long receiver hold-off, started by toggling hold_req
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_cycles <= 3000;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // receiver: random stalls plus the long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_msgs.size() == 0) begin
        report_mismatch("unexpected result", 0, out_tdata[50:18]);
      end else begin
        note_msg_t m;
        m = expected_msgs.pop_front();
        if (out_tuser[1:0] != m.status) report_mismatch("status", m.status, out_tuser[1:0]);
        if (out_tuser[2] != m.kind) report_mismatch("kind", m.kind, out_tuser[2]);
        if (out_tdata[3:0] != m.channel) report_mismatch("channel", m.channel, out_tdata[3:0]);
        if (out_tdata[10:4] != m.note) report_mismatch("note", m.note, out_tdata[10:4]);
        if (out_tdata[17:11] != m.vel) report_mismatch("velocity", m.vel, out_tdata[17:11]);
        if (out_tdata[50:18] != m.tick) report_mismatch("time_tick", m.tick, out_tdata[50:18]);
        if (out_tlast != m.last) report_mismatch("last", m.last, out_tlast);
      end
    end
  end

  function automatic void queue_result(note_msg_t m);
    expected_msgs = {expected_msgs, m};
  endfunction

  function automatic bit ordered_first(sort_entry_t a, sort_entry_t b);
    if (a.tick != b.tick) return a.tick < b.tick;
    if (a.kind != b.kind) return a.kind == lpns_pkg::KIND_OFF;
    if (a.rep != b.rep) return a.rep < b.rep;
    return a.slot < b.slot;
  endfunction

  // repeat range in which table entry e lands inside the window
  function automatic bit repeat_range(int e, longint unsigned ws, longint unsigned we,
                                      longint unsigned first, longint unsigned lst,
                                      output longint unsigned lo, output longint unsigned hi);
    longint unsigned len, off, a, b;
    len = phrase_len;
    off = tbl_off[e];
    lo = 0;
    hi = 0;
    if (off > we - 1) return 0;
    a = (off >= ws) ? 0 : (ws - off + len - 1) / len;
    b = (we - 1 - off) / len;
    if (a < first) a = first;
    if (b > lst) b = lst;
    if (a > b) return 0;
    lo = a;
    hi = b;
    return 1;
  endfunction

  function automatic void push_status(logic [1:0] st);
    note_msg_t m;
    m = '{status: st, kind: 1'b0, channel: 4'd0, note: 7'd0, vel: 7'd0, tick: 33'd0,
          last: 1'b1};
    queue_result(m);
  endfunction

  function automatic void predict_window(logic [31:0] ws_in, logic [31:0] we_in);
    longint unsigned ws, we, first, lst, lo, hi, total, t;
    sort_entry_t pend [lpns_pkg::MAX_PENDING];
    sort_entry_t cur;
    note_msg_t m;
    int n, j;
    ws = ws_in;
    we = we_in;
    total = 0;
    n = 0;
    if (we <= ws || phrase_len == 0) return;
    first = ws / phrase_len;
    lst = (we - 1) / phrase_len;
    for (int e = 0; e < tbl_count; e++) begin
      if (repeat_range(e, ws, we, first, lst, lo, hi)) begin
        total += 2 * (hi - lo + 1);
        if (total > lpns_pkg::MAX_PENDING) begin
          push_status(lpns_pkg::ST_OVF);
          return;
        end
      end
    end
    if (total == 0) return;
    for (int e = 0; e < tbl_count; e++) begin
      if (!repeat_range(e, ws, we, first, lst, lo, hi)) continue;
      for (longint unsigned k = lo; k <= hi; k++) begin
        t = k * phrase_len + tbl_off[e];
        pend[n] = '{tick: 33'(t), kind: lpns_pkg::KIND_ON, rep: k, slot: e,
                    note: tbl_note[e], vel: tbl_vel[e]};
        pend[n + 1] = '{tick: 33'(t + tbl_dur[e]), kind: lpns_pkg::KIND_OFF, rep: k,
                        slot: e, note: tbl_note[e], vel: 7'd0};
        n += 2;
      end
    end
    for (int i = 1; i < n; i++) begin
      cur = pend[i];
      j = i;
      while (j > 0 && ordered_first(cur, pend[j - 1])) begin
        pend[j] = pend[j - 1];
        j--;
      end
      pend[j] = cur;
    end
    for (int i = 0; i < n; i++) begin
      m = '{status: lpns_pkg::ST_MSG, kind: pend[i].kind, channel: midi_chan,
            note: pend[i].note, vel: pend[i].vel, tick: pend[i].tick, last: (i == n - 1)};
      queue_result(m);
    end
  endfunction

  function automatic void predict_request(request_t r);
    case (r.op)
      lpns_pkg::OP_CLEAR: tbl_count = 0;
      lpns_pkg::OP_ADD: begin
        if (tbl_count >= lpns_pkg::MAX_EVENTS) begin
          push_status(lpns_pkg::ST_FULL);
        end else begin
          tbl_off[tbl_count] = r.ev_tick;
          tbl_note[tbl_count] = r.ev_note;
          tbl_vel[tbl_count] = r.ev_vel;
          tbl_dur[tbl_count] = r.ev_dur;
          tbl_count++;
        end
      end
      lpns_pkg::OP_SCHED: predict_window(r.win_start, r.win_end);
      default: ;
    endcase
  endfunction

  task automatic send_request(request_t r);
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= r.op;
    in_tdata <= {2'b00, r.win_end, r.win_start, r.ev_dur, r.ev_vel, r.ev_note, r.ev_tick};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_request(r);
  endtask

  task automatic send_op(logic [1:0] op);
    request_t r;
    r = '{op: op, ev_tick: $urandom, ev_note: 7'($urandom), ev_vel: 7'($urandom),
          ev_dur: $urandom, win_start: $urandom, win_end: $urandom};
    send_request(r);
  endtask

  task automatic send_add(logic [31:0] off, logic [6:0] note, logic [6:0] vel,
                          logic [31:0] dur);
    request_t r;
    r = '{op: lpns_pkg::OP_ADD, ev_tick: off, ev_note: note, ev_vel: vel, ev_dur: dur,
          win_start: $urandom, win_end: $urandom};
    send_request(r);
  endtask

  task automatic send_window(logic [31:0] ws, logic [31:0] we);
    request_t r;
    r = '{op: lpns_pkg::OP_SCHED, ev_tick: $urandom, ev_note: 7'($urandom),
          ev_vel: 7'($urandom), ev_dur: $urandom, win_start: ws, win_end: we};
    send_request(r);
  endtask

  // drain results, then let the block finish any request without results
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_msgs.size() != 0) @(posedge clk);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic addr, logic [31:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == lpns_pkg::CFG_LEN) phrase_len = value;
    else midi_chan = value[3:0];
  endtask

  task automatic test_table_ops();
    send_add(32'd0, 7'd127, 7'd127, 32'd0);       // off and on at one tick
    send_add(32'd100, 7'd0, 7'd0, 32'd3840);
    send_window(32'd0, 32'd7680);
    send_window(32'd5, 32'd5);                    // empty window
    send_window(32'd10, 32'd3);
    send_op(OP_UNUSED);
    send_op(lpns_pkg::OP_CLEAR);
    for (int i = 0; i < lpns_pkg::MAX_EVENTS; i++)
      send_add($urandom_range(3839), 7'($urandom), 7'($urandom), $urandom_range(5000));
    send_add(32'hFFFF_FFFF, 7'h7F, 7'h7F, 32'hFFFF_FFFF);  // table full
    send_window(32'd0, 32'd7680);
    send_window(32'd0, 32'd7681);                 // overflows only when an entry has offset 0
  endtask

  task automatic test_config_extremes();
    write_reg(lpns_pkg::CFG_LEN, 32'd0);
    write_reg(lpns_pkg::CFG_CHAN, 32'd15);
    send_window(32'd0, 32'd1000);                 // zero phrase length
    write_reg(lpns_pkg::CFG_LEN, 32'hFFFF_FFFF);
    send_op(lpns_pkg::OP_CLEAR);
    send_add(32'hFFFF_FFF5, 7'd64, 7'd1, 32'hFFFF_FFFF);
    send_add(32'd3, 7'd1, 7'd2, 32'd0);
    send_window(32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_window(32'd0, 32'hFFFF_FFFF);
    write_reg(lpns_pkg::CFG_LEN, 32'd1);
    send_op(lpns_pkg::OP_CLEAR);
    send_add(32'd0, 7'd5, 7'd6, 32'd1);
    send_window(32'd7, 32'd39);
    write_reg(lpns_pkg::CFG_CHAN, 32'd0);
  endtask

  task automatic test_random_phase(int s_idle, int r_idle, int n_items);
    int sent, n_ev;
    int unsigned len;
    sent = 0;
    send_idle = s_idle;
    recv_idle = r_idle;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom : $urandom_range(200, 8);
      write_reg(lpns_pkg::CFG_LEN, len);
      write_reg(lpns_pkg::CFG_CHAN, $urandom);
      send_op(lpns_pkg::OP_CLEAR);
      n_ev = $urandom_range(6, 1);
      for (int i = 0; i < n_ev; i++) begin
        if ($urandom_range(7) == 0)
          send_add($urandom, 7'($urandom), 7'($urandom), $urandom);
        else
          send_add($urandom_range(len - 1), 7'($urandom), 7'($urandom),
                   $urandom_range(3 * len));
      end
      sent += n_ev + 1;
      for (int i = 0; i < 5; i++) begin
        logic [31:0] ws;
        case ($urandom_range(9))
          0: send_window($urandom, $urandom);
          1: send_op(OP_UNUSED);
          default: begin
            ws = $urandom_range(20000);
            send_window(ws, ws + $urandom_range(2 * len, 1));
          end
        endcase
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    write_reg(lpns_pkg::CFG_LEN, 32'd64);
    send_op(lpns_pkg::OP_CLEAR);
    for (int i = 0; i < 4; i++)
      send_add($urandom_range(63), 7'($urandom), 7'($urandom), $urandom_range(100));
    hold_req = ~hold_req;
    for (int i = 0; i < 4; i++) send_window(32'd0, 32'd256);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    phrase_len = 32'd3840;
    midi_chan = 4'd0;
    tbl_count = 0;
    test_table_ops();
    test_config_extremes();
    test_random_phase(11, 88, 35);
    test_random_phase(88, 11, 35);
    test_random_phase(0, 0, 35);
    test_backpressure();
    wait_idle();
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_msgs.size() == 0)
      $display("looped_phrase_note_scheduler_tb OK");
    else
      $display("looped_phrase_note_scheduler_tb NOT OK");
    $finish;
  end

  initial begin
    #200000000;
    $display("looped_phrase_note_scheduler_tb NOT OK");
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/lpns_pkg.sv
src/looped_phrase_note_scheduler.sv
tb/looped_phrase_note_scheduler_tb.sv
